>>> sv/streaming_substring_search_macros.svh
// assertion macros shared by the substring search rtl
// expects clk_i and rst_ni in the scope of each use
`ifndef STREAMING_SUBSTRING_SEARCH_MACROS_SVH
`define STREAMING_SUBSTRING_SEARCH_MACROS_SVH

// same-cycle implication, disabled in reset
`define SSS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define SSS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/sss_pkg.sv
// shared types and constants for the streaming substring search
// no dependencies
`default_nettype none

package sss_pkg;

  // window depth default, longest supported pattern
  localparam int unsigned MaxPatternDef = 8;

  // field widths fixed by the interface
  localparam int unsigned ByteW     = 8;
  localparam int unsigned PatBytesW = 64;
  localparam int unsigned PatLenW   = 4;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned StatusW   = 2;

  localparam logic [ByteW-1:0] NewlineChar = 8'h0A;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegPatternBytes  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegPatternLength = 2'd1;

  // search result codes
  typedef enum logic [StatusW-1:0] {
    StatusRejected = 2'd0,
    StatusFound    = 2'd1,
    StatusNotFound = 2'd2
  } search_status_e;

  // per-beat control shared by every cell
  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

  // pattern character a cell compares against
  typedef struct packed {
    logic [ByteW-1:0] expect_byte;
    logic             in_use;
  } cell_ref_t;

endpackage

`default_nettype wire

>>> sv/sss_cell.sv
// one window cell: holds a text byte and its valid bit, passes both on
// depends on sss_pkg
`default_nettype none

module sss_cell (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire sss_pkg::cell_ctrl_t      ctrl_i,
  input  wire sss_pkg::cell_ref_t       ref_i,
  input  wire logic [sss_pkg::ByteW-1:0] byte_i,
  input  wire logic                     valid_i,
  output logic      [sss_pkg::ByteW-1:0] byte_o,
  output logic                          valid_o,
  output logic                          hit_o
);

  logic [sss_pkg::ByteW-1:0] byte_q;
  logic                      valid_q;

  // byte payload moves one cell down on every beat
  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      byte_q <= byte_i;
    end
  end

  // valid bit follows the byte, cleared at the end of a text
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctrl_i.shift) begin
      valid_q <= valid_i & ~ctrl_i.clear;
    end
  end

  // compare the byte this cell is about to hold
  assign hit_o   = ~ref_i.in_use | (valid_i & (byte_i == ref_i.expect_byte));
  assign byte_o  = byte_q;
  assign valid_o = valid_q;

endmodule

`default_nettype wire

>>> sv/streaming_substring_search.sv
// top level of the streaming substring search: config registers, cell row, result register
// depends on sss_pkg, sss_cell and streaming_substring_search_macros.svh
`default_nettype none

// Text bytes stream in one per beat on the s_axis side, tlast on the final byte of a
// text. A row of MAX_PATTERN cells holds the newest bytes; on every beat each cell
// compares the byte it is about to hold with its pattern character, so the whole
// window is checked in the cycle the byte is taken; one byte is accepted every clock
// if no status beat waits. On the final byte one status beat (0 rejected for a leading
// newline in text or pattern, 1 found, 2 not found) is loaded into the output register
// and appears on m_axis the next cycle; input keeps flowing while that beat is taken
// the same cycle. cfg sets the pattern (index 0 bytes, 1 length, others ignored); the user
// must write it only between texts, unenforced; a new text starts right after a final byte.
`include "streaming_substring_search_macros.svh"

module streaming_substring_search #(
  parameter int unsigned MAX_PATTERN = sss_pkg::MaxPatternDef
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // configuration writes
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [sss_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [sss_pkg::PatBytesW-1:0] cfg_data_i,
  // text in
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  input  wire logic [7:0]                   s_axis_tdata,  // [7:0] text_byte
  input  wire logic                         s_axis_tlast,  // last_byte
  // result out
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  output logic      [7:0]                   m_axis_tdata   // [1:0] search_status
);

  localparam int unsigned ByteW = sss_pkg::ByteW;
  localparam int unsigned LenW  = sss_pkg::PatLenW;

  logic [sss_pkg::PatBytesW-1:0] pattern_bytes_q;
  logic [LenW-1:0]               pattern_length_q;
  logic [LenW-1:0]               len_cap;

  logic                   in_accept;
  sss_pkg::cell_ctrl_t    cell_ctrl;
  logic [ByteW-1:0]       win_byte  [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] win_valid;
  logic [MAX_PATTERN-1:0] cell_hit;

  logic                   match_seen_q;
  logic                   leading_newline_q;
  logic                   leading_now;
  logic                   pattern_nl;
  logic                   match_now;
  logic                   out_valid_q;
  sss_pkg::search_status_e status_q;
  sss_pkg::search_status_e status_d;

  // config registers, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_bytes_q  <= '0;
      pattern_length_q <= LenW'(1);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        sss_pkg::RegPatternBytes:  pattern_bytes_q  <= cfg_data_i;
        sss_pkg::RegPatternLength: pattern_length_q <= cfg_data_i[LenW-1:0];
        default: ;
      endcase
    end
  end

  // active length saturates at the window depth
  assign len_cap = (pattern_length_q > LenW'(MAX_PATTERN)) ? LenW'(MAX_PATTERN)
                                                           : pattern_length_q;

  // beat control
  assign s_axis_tready   = ~out_valid_q | m_axis_tready;
  assign in_accept       = s_axis_tvalid & s_axis_tready;
  assign cell_ctrl.shift = in_accept;
  assign cell_ctrl.clear = s_axis_tlast;

  // row of window cells, cell 0 holds the newest byte
  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    logic [2:0]          pat_idx;
    sss_pkg::cell_ref_t  cell_ref;
    logic [ByteW-1:0]    chain_byte;
    logic                chain_valid;

    // cell k lines up with pattern character len-1-k
    assign pat_idx              = 3'(len_cap - LenW'(k) - LenW'(1));
    assign cell_ref.in_use      = (LenW'(k) < len_cap);
    assign cell_ref.expect_byte = pattern_bytes_q[{pat_idx, 3'b000} +: ByteW];

    if (k == 0) begin : g_head
      assign chain_byte  = s_axis_tdata;
      assign chain_valid = 1'b1;
    end else begin : g_body
      assign chain_byte  = win_byte[k-1];
      assign chain_valid = win_valid[k-1];
    end

    sss_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (cell_ctrl),
      .ref_i   (cell_ref),
      .byte_i  (chain_byte),
      .valid_i (chain_valid),
      .byte_o  (win_byte[k]),
      .valid_o (win_valid[k]),
      .hit_o   (cell_hit[k])
    );
  end

  // per-text flags including the current beat
  assign match_now   = match_seen_q | (&cell_hit);
  assign leading_now = leading_newline_q | (~win_valid[0] & (s_axis_tdata == sss_pkg::NewlineChar));
  assign pattern_nl  = (pattern_length_q != '0) &
                       (pattern_bytes_q[ByteW-1:0] == sss_pkg::NewlineChar);

  // status of a text ending on this beat
  always_comb begin
    priority if (leading_now | pattern_nl) begin
      status_d = sss_pkg::StatusRejected;
    end else if (match_now) begin
      status_d = sss_pkg::StatusFound;
    end else begin
      status_d = sss_pkg::StatusNotFound;
    end
  end

  // per-text flags, cleared after the final byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_seen_q      <= 1'b0;
      leading_newline_q <= 1'b0;
    end else if (in_accept) begin
      match_seen_q      <= match_now & ~s_axis_tlast;
      leading_newline_q <= leading_now & ~s_axis_tlast;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept & s_axis_tlast) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept & s_axis_tlast) begin
      status_q <= status_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(8 - sss_pkg::StatusW){1'b0}}, status_q};

  // checks
  `SSS_ASSERT_NEXT(a_last_gives_result, in_accept && s_axis_tlast, m_axis_tvalid,
    "final byte did not produce a result beat")
  `SSS_ASSERT_NEXT(a_last_clears_window, in_accept && s_axis_tlast,
    win_valid == '0 && !match_seen_q && !leading_newline_q,
    "per-text state not cleared after final byte")
  `SSS_ASSERT_NEXT(a_byte_fills_head, in_accept && !s_axis_tlast, win_valid[0],
    "newest window cell not valid after a byte")
  `SSS_ASSERT_NEXT(a_newline_pattern_rejects, in_accept && s_axis_tlast && pattern_nl,
    status_q == sss_pkg::StatusRejected, "newline pattern not rejected")

endmodule

`default_nettype wire
